/* design/nnue_pkg.sv */
// ----------------------------------------------------------------------------
// nnue_pkg
// Shared types and constants of the incremental accumulator evaluator.
// ----------------------------------------------------------------------------
package nnue_pkg;

    localparam int HIDDEN_UNITS  = 256;
    localparam int HID_W         = $clog2(HIDDEN_UNITS);
    localparam int SIDE_OFFSET   = 64 * 6;
    localparam int KIND_STRIDE   = 64;
    localparam int FEATURE_COUNT = SIDE_OFFSET * 2;
    localparam int FEAT_W        = $clog2(FEATURE_COUNT);
    localparam int FW_DEPTH      = FEATURE_COUNT * HIDDEN_UNITS;
    localparam int FW_ADDR_W     = $clog2(FW_DEPTH);
    localparam int SCORE_W       = 20;

    typedef enum logic [2:0] {
        OP_WRITE_WEIGHT = 3'd0,
        OP_WRITE_BIAS   = 3'd1,
        OP_WRITE_OUTW   = 3'd2,
        OP_RESET_ACC    = 3'd3,
        OP_ADD          = 3'd4,
        OP_REMOVE       = 3'd5,
        OP_EVAL         = 3'd6,
        OP_NONE         = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic               piece_side;
        logic [2:0]         piece_kind;
        logic [5:0]         board_square;
        logic [7:0]         hidden_position;
        logic signed [15:0] weight_value;
        logic               side_to_move;
    } in_word_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      score_valid;
    } out_word_t;

    localparam logic [0:0] REG_OUTPUT_BIAS = 1'b0;

endpackage

/* design/nnue_walk.sv */
// ----------------------------------------------------------------------------
// nnue_walk
// Accumulator memory with a read-modify-write walk over all hidden units,
// plus the output-layer multiply-accumulate for evaluation.
// ----------------------------------------------------------------------------
module nnue_walk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [2:0]                     op,
    input  logic                           side,
    input  logic [31:0]                    bias,
    input  logic                           fw_we,
    input  logic [nnue_pkg::FW_ADDR_W-1:0] fw_waddr,
    input  logic [nnue_pkg::FEAT_W-1:0]    feat,
    input  logic                           hw_we,
    input  logic                           ow_we,
    input  logic [nnue_pkg::HID_W-1:0]     h_waddr,
    input  logic [15:0]                    wdata,
    output logic                           done,
    output logic signed [nnue_pkg::SCORE_W-1:0] score
);

    localparam int HU = nnue_pkg::HIDDEN_UNITS;
    localparam int HW = nnue_pkg::HID_W;

    logic [15:0] fw_mem [nnue_pkg::FW_DEPTH];
    logic [15:0] hb_mem [HU];
    logic [15:0] ow_mem [HU];
    logic [15:0] acc_mem [HU];

    logic          run_reg, run_next;
    logic [HW:0]   rcnt_reg, rcnt_next;
    logic          rd_v_reg;
    logic [HW-1:0] rd_a_reg;
    logic          mul_v_reg;
    logic signed [31:0] prod_reg;
    logic [31:0]   sum_reg;
    logic [2:0]    op_reg;
    logic          side_reg;
    logic [nnue_pkg::FEAT_W-1:0] feat_reg;
    logic          fin_reg;
    logic [1:0]    tail_reg;
    logic [15:0]   fw_q, hb_q, ow_q, acc_q;
    logic [nnue_pkg::FW_ADDR_W-1:0] fw_raddr;
    logic [15:0]   acc_new;
    logic signed [31:0] ssum, sq;
    logic signed [31:0] sneg;

    assign fw_raddr = nnue_pkg::FW_ADDR_W'({feat_reg, rcnt_reg[HW-1:0]});

    always_ff @(posedge clk)
    begin
        if (fw_we)
        begin
            fw_mem[fw_waddr] <= wdata;
        end
        if (hw_we)
        begin
            hb_mem[h_waddr] <= wdata;
        end
        if (ow_we)
        begin
            ow_mem[h_waddr] <= wdata;
        end
        fw_q  <= fw_mem[fw_raddr];
        hb_q  <= hb_mem[rcnt_reg[HW-1:0]];
        ow_q  <= ow_mem[rcnt_reg[HW-1:0]];
        acc_q <= acc_mem[rcnt_reg[HW-1:0]];
        if (rd_v_reg && op_reg != 3'(nnue_pkg::OP_EVAL))
        begin
            acc_mem[rd_a_reg] <= acc_new;
        end
    end

    // each address is read once and written in the next cycle: no overlap
    always_comb
    begin
        case (op_reg)
            3'(nnue_pkg::OP_RESET_ACC): acc_new = hb_q;
            3'(nnue_pkg::OP_ADD):       acc_new = acc_q + fw_q;
            default:                    acc_new = acc_q - fw_q;
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        rcnt_next = rcnt_reg;
        if (start)
        begin
            run_next  = 1'b1;
            rcnt_next = '0;
        end
        else if (run_reg)
        begin
            rcnt_next = rcnt_reg + 1'b1;
            if (rcnt_reg == (HW+1)'(HU - 1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            rcnt_reg  <= '0;
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            fin_reg   <= 1'b0;
            tail_reg  <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            rcnt_reg  <= rcnt_next;
            rd_v_reg  <= run_reg;
            mul_v_reg <= rd_v_reg && op_reg == 3'(nnue_pkg::OP_EVAL);
            tail_reg  <= {tail_reg[0], rd_v_reg && !run_reg};
            fin_reg   <= tail_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            side_reg <= side;
            feat_reg <= feat;
            sum_reg  <= bias;
        end
        rd_a_reg <= rcnt_reg[HW-1:0];
        prod_reg <= ($signed(acc_q) > 0) ? $signed(acc_q) * $signed(ow_q) : 32'sd0;
        if (mul_v_reg && !start)
        begin
            sum_reg <= sum_reg + prod_reg;
        end
    end

    assign ssum = $signed(sum_reg);
    assign sq   = (ssum + ((ssum < 0) ? 32'sd4095 : 32'sd0)) >>> 12;
    assign sneg = side_reg ? -sq : sq;
    assign score = (sneg > 32'sd524287) ? nnue_pkg::SCORE_W'(524287)
                                        : sneg[nnue_pkg::SCORE_W-1:0];
    assign done = fin_reg;

endmodule

/* design/nnue_accumulator_eval_core.sv */
// ----------------------------------------------------------------------------
// nnue_accumulator_eval_core
// Incremental two-layer network evaluator with APB bias register.
// ----------------------------------------------------------------------------
// Weight and bias writes need no walk. Accumulator reset, add and remove (with a
// valid piece kind) and evaluate walk all hidden units through one port of
// each memory, one unit a cycle. A finished result waits in an output register;
// the next word is taken once both the walk and that register are free.
module nnue_accumulator_eval_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nnue_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nnue_pkg::out_word_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [31:0] bias_reg;
    logic        busy_reg, busy_next;
    logic        ov_reg, ov_next;
    nnue_pkg::out_word_t od_reg;
    logic        acc, walk, kind_ok, pos_ok, done, res_free;
    logic [nnue_pkg::FEAT_W-1:0] feat;
    logic signed [nnue_pkg::SCORE_W-1:0] wscore;
    logic [2:0]  op;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == nnue_pkg::REG_OUTPUT_BIAS) ? bias_reg : 32'd0;

    assign op      = in_data.operation;
    assign kind_ok = in_data.piece_kind < 3'd6;
    assign pos_ok  = 32'(in_data.hidden_position) < nnue_pkg::HIDDEN_UNITS;
    assign feat    = nnue_pkg::FEAT_W'(in_data.piece_side)
                     * nnue_pkg::FEAT_W'(nnue_pkg::SIDE_OFFSET)
                   + nnue_pkg::FEAT_W'(in_data.piece_kind)
                     * nnue_pkg::FEAT_W'(nnue_pkg::KIND_STRIDE)
                   + nnue_pkg::FEAT_W'(in_data.board_square);
    assign res_free = !ov_reg || out_ready;
    assign in_ready = !busy_reg && res_free;
    assign acc      = in_valid && in_ready;
    assign walk     = acc && (op == 3'(nnue_pkg::OP_RESET_ACC) || op == 3'(nnue_pkg::OP_EVAL)
                   || ((op == 3'(nnue_pkg::OP_ADD) || op == 3'(nnue_pkg::OP_REMOVE)) && kind_ok));

    nnue_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk),
        .op       (op),
        .side     (in_data.side_to_move),
        .bias     (bias_reg),
        .fw_we    (acc && op == 3'(nnue_pkg::OP_WRITE_WEIGHT) && kind_ok && pos_ok),
        .fw_waddr (nnue_pkg::FW_ADDR_W'({feat, in_data.hidden_position[nnue_pkg::HID_W-1:0]})),
        .feat     (feat),
        .hw_we    (acc && op == 3'(nnue_pkg::OP_WRITE_BIAS) && pos_ok),
        .ow_we    (acc && op == 3'(nnue_pkg::OP_WRITE_OUTW) && pos_ok),
        .h_waddr  (in_data.hidden_position[nnue_pkg::HID_W-1:0]),
        .wdata    (in_data.weight_value),
        .done     (done),
        .score    (wscore)
    );

    logic eval_reg;

    always_comb
    begin
        ov_next   = ov_reg;
        busy_next = busy_reg;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        if (walk)
        begin
            busy_next = 1'b1;
        end
        else if (acc)
        begin
            ov_next = 1'b1;
        end
        if (done && busy_reg)
        begin
            busy_next = 1'b0;
            ov_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            eval_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[1] == nnue_pkg::REG_OUTPUT_BIAS)
            begin
                bias_reg <= pwdata;
            end
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            if (walk)
            begin
                eval_reg <= op == 3'(nnue_pkg::OP_EVAL);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !walk)
        begin
            od_reg <= '0;
        end
        else if (done && busy_reg)
        begin
            od_reg.score       <= eval_reg ? wscore : '0;
            od_reg.score_valid <= eval_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule
